### hdl/wchid_pkg.sv
package wchid_pkg;

	localparam int ADDR_W     = 48;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CHIP_ID = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd3;

	localparam logic [15:0] CHIP_ID_RESET = 16'd38176;
	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

	localparam logic [2:0] STAGE_ID  = 3'd0;
	localparam logic [2:0] STAGE_LDO = 3'd1;
	localparam logic [2:0] STAGE_B6  = 3'd2;
	localparam logic [2:0] STAGE_B7  = 3'd3;

	localparam logic [1:0] STATUS_RUNNING = 2'd0;
	localparam logic [1:0] STATUS_DONE    = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

	localparam logic [7:0] FLAG_LDO   = 8'h40;
	localparam logic [7:0] FLAG_REPLY = 8'h10;
	localparam logic [7:0] ACK_A      = 8'h1E;
	localparam logic [7:0] ACK_B      = 8'hFF;

	localparam logic [7:0] PKT_CHECK = 8'hC1;
	localparam logic [7:0] PKT_ADDR  = 8'hB6;
	localparam logic [7:0] PKT_SWAP  = 8'hB7;

	localparam logic [1:0] GRP_CHECK = 2'd0;
	localparam logic [1:0] GRP_ADDR  = 2'd1;
	localparam logic [1:0] GRP_SWAP  = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] device_address;
		logic [7:0]        header_byte;
		logic [15:0]       expected_chip_id;
		logic [15:0]       timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [15:0] chip_id;
		logic [7:0]  int_flags;
		logic [7:0]  ack_first;
		logic [7:0]  ack_second;
		logic        link_ready;
	} in_item_t;

	typedef struct packed {
		logic        send_packet;
		logic [7:0]  packet_header;
		logic [7:0]  packet_type;
		logic [23:0] payload;
		logic        charge_start;
		logic        discharge_request;
		logic        charger_present;
		logic [1:0]  init_status;
		logic [2:0]  stage;
	} out_item_t;

	function automatic logic [23:0] payload_of(input logic [ADDR_W-1:0] addr,
		input logic [1:0] grp);
		logic [7:0]  m [6];
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  x;
		logic [23:0] r;
		for (int k = 0; k < 6; k++) begin
			m[k] = addr[ADDR_W-1-8*k -: 8];
		end
		r = '0;
		for (int i = 0; i < 3; i++) begin
			a = {m[i+3][3:0], m[i][7:4]};
			b = {m[i][3:0], m[i+3][7:4]};
			x = a ^ b;
			case (grp)
				GRP_ADDR:  r[23-8*i -: 8] = a;
				GRP_SWAP:  r[23-8*i -: 8] = b;
				default:   r[23-8*i -: 8] = {x[3:0], x[7:4]};
			endcase
		end
		return r;
	endfunction

endpackage

### hdl/wchid_in_if.sv
interface wchid_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] chip_id;
	logic [7:0]  int_flags;
	logic [7:0]  ack_first;
	logic [7:0]  ack_second;
	logic        link_ready;

	modport source (output valid, chip_id, int_flags, ack_first, ack_second, link_ready,
		input ready);
	modport sink (input valid, chip_id, int_flags, ack_first, ack_second, link_ready,
		output ready);
endinterface

### hdl/wchid_out_if.sv
interface wchid_out_if;
	logic        valid;
	logic        ready;
	logic        send_packet;
	logic [7:0]  packet_header;
	logic [7:0]  packet_type;
	logic [23:0] payload;
	logic        charge_start;
	logic        discharge_request;
	logic        charger_present;
	logic [1:0]  init_status;
	logic [2:0]  stage;

	modport source (output valid, send_packet, packet_header, packet_type, payload,
		charge_start, discharge_request, charger_present, init_status, stage,
		input ready);
	modport sink (input valid, send_packet, packet_header, packet_type, payload,
		charge_start, discharge_request, charger_present, init_status, stage,
		output ready);
endinterface

### hdl/wireless_charge_id_handshake_unit.sv
// Charger identification handshake, one item per tick.
// Channel in carries the tick: chip identity read, interrupt flags, the two
// acknowledge bytes and whether the transmit path takes a packet this tick.
// Channel out returns exactly one item per tick: the packet to send (if any),
// the charge and discharge pulses, presence, status and the stage after it.
// Configuration is a write port (cfg_we, cfg_index, cfg_data); write only
// while no tick is in flight.
// An accepted tick passes the input register, then the result register, before
// it shows on out. Throughput: one tick per cycle while out does not stall; the
// handshake state is updated in the same cycle the result register loads.
// Reset clears the stage, tick counter, status and presence, and loads the
// registers with their reset values (expected id 0x9520, timeout 2000).
// When out stalls, the result register holds and the input register still
// takes one more tick; then in.ready drops until out drains.
module wireless_charge_id_handshake_unit
	import wchid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wchid_in_if.sink              in,
	wchid_out_if.source           out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      take_s2;
	logic      halted;

	wchid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign take_s2  = valid_s1 && (!valid_s2 || out.ready);
	assign in.ready = !valid_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			item_s1 <= '{chip_id: in.chip_id, int_flags: in.int_flags,
				ack_first: in.ack_first, ack_second: in.ack_second,
				link_ready: in.link_ready};
		end
	end

	wchid_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (take_s2),
		.item   (item_s1),
		.res    (res),
		.halted (halted)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			res_s2 <= res;
		end
	end

	assign out.valid             = valid_s2;
	assign out.send_packet       = res_s2.send_packet;
	assign out.packet_header     = res_s2.packet_header;
	assign out.packet_type       = res_s2.packet_type;
	assign out.payload           = res_s2.payload;
	assign out.charge_start      = res_s2.charge_start;
	assign out.discharge_request = res_s2.discharge_request;
	assign out.charger_present   = res_s2.charger_present;
	assign out.init_status       = res_s2.init_status;
	assign out.stage             = res_s2.stage;

	a_charge_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.charge_start) |-> (out.stage == STAGE_LDO && out.charger_present))
		else $error("charge pulse without move to LDO stage");

	a_discharge_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.discharge_request) |-> (out.stage == STAGE_ID && !out.send_packet))
		else $error("discharge pulse outside identity stage");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out.ready) |-> !in.ready)
		else $error("input taken while both registers are full");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s2 && halted) |=> (!res_s2.send_packet && !res_s2.charge_start
			&& !res_s2.discharge_request))
		else $error("activity after sequence halted");

endmodule

### hdl/wchid_cfg.sv
module wchid_cfg
	import wchid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address   <= '0;
			cfg_q.header_byte      <= '0;
			cfg_q.expected_chip_id <= CHIP_ID_RESET;
			cfg_q.timeout_ticks    <= TIMEOUT_RESET;
		end else if (we) begin
			case (index)
				REG_DEVICE_ADDRESS:   cfg_q.device_address   <= data[ADDR_W-1:0];
				REG_HEADER_BYTE:      cfg_q.header_byte      <= data[7:0];
				REG_EXPECTED_CHIP_ID: cfg_q.expected_chip_id <= data[15:0];
				REG_TIMEOUT_TICKS:    cfg_q.timeout_ticks    <= data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/wchid_core.sv
module wchid_core
	import wchid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t res,
	output logic      halted
);

	logic [2:0]  stage_q, stage_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [1:0]  status_q, status_d;
	logic        present_q, present_d;
	logic        halted_q, halted_d;

	logic        send, chg, dis, ack_ok;
	logic [7:0]  ptype;
	logic [1:0]  grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= STAGE_ID;
			elapsed_q <= '0;
			status_q  <= STATUS_RUNNING;
			present_q <= 1'b0;
			halted_q  <= 1'b0;
		end else if (step) begin
			stage_q   <= stage_d;
			elapsed_q <= elapsed_d;
			status_q  <= status_d;
			present_q <= present_d;
			halted_q  <= halted_d;
		end
	end

	always_comb begin
		ack_ok    = ((item.int_flags & FLAG_REPLY) != '0) && item.ack_first == ACK_A
			&& item.ack_second == ACK_B;
		send      = 1'b0;
		chg       = 1'b0;
		dis       = 1'b0;
		ptype     = '0;
		grp       = GRP_CHECK;
		stage_d   = stage_q;
		elapsed_d = elapsed_q;
		status_d  = status_q;
		present_d = present_q;
		halted_d  = halted_q;
		if (!halted_q) begin
			case (stage_q)
				STAGE_ID: begin
					if (item.chip_id == cfg.expected_chip_id) begin
						chg       = 1'b1;
						present_d = 1'b1;
						stage_d   = STAGE_LDO;
					end else begin
						dis = 1'b1;
					end
				end
				STAGE_LDO: begin
					if ((item.int_flags & FLAG_LDO) != '0) begin
						send  = 1'b1;
						ptype = PKT_CHECK;
						grp   = GRP_CHECK;
					end
				end
				STAGE_B6: begin
					if (ack_ok) begin
						send  = 1'b1;
						ptype = PKT_ADDR;
						grp   = GRP_ADDR;
					end
				end
				STAGE_B7: begin
					if (ack_ok) begin
						send  = 1'b1;
						ptype = PKT_SWAP;
						grp   = GRP_SWAP;
					end
				end
				default: begin
					status_d = STATUS_DONE;
					halted_d = 1'b1;
				end
			endcase
			if (send && item.link_ready) begin
				stage_d = stage_q + 3'd1;
			end
			if (elapsed_q != TICKS_MAX) begin
				elapsed_d = elapsed_q + 16'd1;
			end
			if (elapsed_d >= cfg.timeout_ticks) begin
				status_d = STATUS_TIMEOUT;
			end
		end
	end

	always_comb begin
		res.send_packet       = send;
		res.packet_header     = send ? cfg.header_byte : 8'd0;
		res.packet_type       = ptype;
		res.payload           = send ? payload_of(cfg.device_address, grp) : 24'd0;
		res.charge_start      = chg;
		res.discharge_request = dis;
		res.charger_present   = present_d;
		res.init_status       = status_d;
		res.stage             = stage_d;
	end

	assign halted = halted_q;

endmodule

### tb/sv/wireless_charge_id_handshake_unit_test.sv
`timescale 1ns / 1ps

module wireless_charge_id_handshake_unit_test;
	import wchid_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] STAGE_END = 3'd4;

	typedef struct {
		in_item_t  tick;
		out_item_t res;
	} tick_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wchid_in_if  tick_ch ();
	wchid_out_if res_ch ();

	wireless_charge_id_handshake_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (tick_ch),
		.out       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [7:0]        cfg_header = '0;
	logic [15:0]       cfg_chip = CHIP_ID_RESET;
	logic [15:0]       cfg_timeout = TIMEOUT_RESET;

	logic [2:0]  hs_stage = STAGE_ID;
	logic [15:0] tick_count = '0;
	logic [1:0]  status = STATUS_RUNNING;
	logic        present = 1'b0;
	logic        halted = 1'b0;

	out_item_t pending_results [$];
	tick_row_t dir_rows [$];
	out_item_t want_res;
	out_item_t got_res;
	int        mismatches = 0;
	int        cycles = 0;
	int        ticks_sent = 0;
	int        packets_sent = 0;
	int        stall_left = 0;
	bit        tx_calm = 1'b0;
	bit        rx_calm = 1'b0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles", $time, cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [23:0] packet_payload(input logic [7:0] ptype);
		logic [7:0]  m [6];
		logic [7:0]  fwd;
		logic [7:0]  rev;
		logic [7:0]  chk;
		logic [23:0] acc;
		for (int k = 0; k < 6; k++)
			m[k] = cfg_addr[47-8*k -: 8];
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			fwd = {m[i+3][3:0], m[i][7:4]};
			rev = {m[i][3:0], m[i+3][7:4]};
			chk = fwd ^ rev;
			acc = acc << 8;
			if (ptype == PKT_ADDR)
				acc[7:0] = fwd;
			else if (ptype == PKT_SWAP)
				acc[7:0] = rev;
			else
				acc[7:0] = {chk[3:0], chk[7:4]};
		end
		return acc;
	endfunction

	function automatic void step_handshake(input in_item_t t, output out_item_t r);
		logic [7:0] ptype;
		logic       ack_ok;
		r = '0;
		ptype = '0;
		ack_ok = ((t.int_flags & FLAG_REPLY) != 0) && t.ack_first == ACK_A
			&& t.ack_second == ACK_B;
		if (!halted) begin
			case (hs_stage)
				STAGE_ID: begin
					if (t.chip_id == cfg_chip) begin
						r.charge_start = 1'b1;
						present = 1'b1;
						hs_stage = STAGE_LDO;
					end else begin
						r.discharge_request = 1'b1;
					end
				end
				STAGE_LDO: if ((t.int_flags & FLAG_LDO) != 0) ptype = PKT_CHECK;
				STAGE_B6: if (ack_ok) ptype = PKT_ADDR;
				STAGE_B7: if (ack_ok) ptype = PKT_SWAP;
				default: begin
					status = STATUS_DONE;
					halted = 1'b1;
				end
			endcase
			if (ptype != 0 && t.link_ready)
				hs_stage = hs_stage + 3'd1;
			if (tick_count != TICKS_MAX)
				tick_count = tick_count + 16'd1;
			if (tick_count >= cfg_timeout)
				status = STATUS_TIMEOUT;
		end
		if (ptype != 0) begin
			r.send_packet = 1'b1;
			r.packet_header = cfg_header;
			r.packet_type = ptype;
			r.payload = packet_payload(ptype);
		end
		r.charger_present = present;
		r.init_status = status;
		r.stage = hs_stage;
	endfunction

	function automatic in_item_t make_tick(input logic [2:0] target);
		in_item_t t;
		int       pick;
		logic     fires;
		t.chip_id = 16'($urandom);
		t.int_flags = 8'($urandom);
		t.ack_first = 8'($urandom);
		t.ack_second = 8'($urandom);
		t.link_ready = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (!halted && hs_stage >= STAGE_LDO && hs_stage <= STAGE_B7 && pick < 85) begin
			if (pick < 60) begin
				if (hs_stage == STAGE_LDO) begin
					t.int_flags |= FLAG_LDO;
				end else begin
					t.int_flags |= FLAG_REPLY;
					t.ack_first = ACK_A;
					t.ack_second = ACK_B;
				end
			end else if (hs_stage == STAGE_LDO) begin
				t.int_flags &= ~FLAG_LDO;
			end else begin
				t.int_flags |= FLAG_REPLY;
				t.ack_first = ACK_A;
				t.ack_second = ACK_B;
				case ($urandom_range(0, 2))
					0: t.int_flags &= ~FLAG_REPLY;
					1: t.ack_first = ACK_A ^ 8'($urandom_range(1, 255));
					default: t.ack_second = ACK_B ^ 8'($urandom_range(1, 255));
				endcase
			end
		end
		// hold the stage once the target is reached
		if (hs_stage == STAGE_LDO)
			fires = (t.int_flags & FLAG_LDO) != 0;
		else
			fires = ((t.int_flags & FLAG_REPLY) != 0) && t.ack_first == ACK_A
				&& t.ack_second == ACK_B;
		if (!halted && hs_stage >= STAGE_LDO && hs_stage <= STAGE_B7 && hs_stage >= target
			&& fires)
			t.link_ready = 1'b0;
		return t;
	endfunction

	function automatic void add_row(input in_item_t t, input out_item_t r);
		dir_rows.push_back('{t, r});
	endfunction

	task automatic send_tick(input in_item_t t, input bit typed, input out_item_t typed_res);
		int        gap;
		out_item_t pred;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if ($urandom_range(0, 23) == 0)
			tx_calm = !tx_calm;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.chip_id <= t.chip_id;
		tick_ch.int_flags <= t.int_flags;
		tick_ch.ack_first <= t.ack_first;
		tick_ch.ack_second <= t.ack_second;
		tick_ch.link_ready <= t.link_ready;
		do @(posedge clk); while (!tick_ch.ready);
		step_handshake(t, pred);
		pending_results.push_back(typed ? typed_res : pred);
		ticks_sent++;
		if (pred.send_packet)
			packets_sent++;
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DEVICE_ADDRESS: cfg_addr = data;
			REG_HEADER_BYTE: cfg_header = data[7:0];
			REG_EXPECTED_CHIP_ID: cfg_chip = data[15:0];
			default: cfg_timeout = data[15:0];
		endcase
	endtask

	task automatic run_phase(input int n, input logic [2:0] target);
		for (int i = 0; i < n; i++)
			send_tick(make_tick(target), 1'b0, '0);
		tick_ch.valid <= 1'b0;
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected", $time);
					mismatches++;
				end else begin
					want_res = pending_results.pop_front();
					got_res = '{send_packet: res_ch.send_packet,
						packet_header: res_ch.packet_header,
						packet_type: res_ch.packet_type,
						payload: res_ch.payload,
						charge_start: res_ch.charge_start,
						discharge_request: res_ch.discharge_request,
						charger_present: res_ch.charger_present,
						init_status: res_ch.init_status,
						stage: res_ch.stage};
					if (got_res !== want_res) begin
						$display("%0t: result expected %0h got %0h", $time, want_res,
							got_res);
						mismatches++;
					end
				end
				stall_left = rx_calm ? 0 : $urandom_range(0, 6);
				if ($urandom_range(0, 23) == 0)
					rx_calm = !rx_calm;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.chip_id = '0;
		tick_ch.int_flags = '0;
		tick_ch.ack_first = '0;
		tick_ch.ack_second = '0;
		tick_ch.link_ready = 1'b0;
		res_ch.ready = 1'b0;

		add_row({16'h0000, 8'h00, 8'h00, 8'h00, 1'b0},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b1, 1'b0, STATUS_RUNNING, STAGE_ID});
		add_row({16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b1, 1'b0, STATUS_RUNNING, STAGE_ID});
		add_row({16'h9521, FLAG_LDO, ACK_A, ACK_B, 1'b1},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b1, 1'b0, STATUS_RUNNING, STAGE_ID});
		add_row({16'h1520, 8'h50, ACK_A, ACK_B, 1'b1},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b1, 1'b0, STATUS_RUNNING, STAGE_ID});
		add_row({CHIP_ID_RESET, 8'h00, 8'h00, 8'h00, 1'b0},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b1, 1'b0, 1'b1, STATUS_RUNNING, STAGE_LDO});
		add_row({CHIP_ID_RESET, 8'h00, ACK_A, ACK_B, 1'b1},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b0, 1'b1, STATUS_RUNNING, STAGE_LDO});
		add_row({16'h0000, 8'hBF, 8'hFF, 8'hFF, 1'b1},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b0, 1'b1, STATUS_RUNNING, STAGE_LDO});
		add_row({16'hFFFF, FLAG_LDO, 8'h00, 8'h00, 1'b0},
			{1'b1, 8'h00, PKT_CHECK, 24'h0, 1'b0, 1'b0, 1'b1, STATUS_RUNNING, STAGE_LDO});
		add_row({16'h0000, 8'hFF, ACK_A, ACK_B, 1'b0},
			{1'b1, 8'h00, PKT_CHECK, 24'h0, 1'b0, 1'b0, 1'b1, STATUS_RUNNING, STAGE_LDO});
		add_row({16'h0000, FLAG_REPLY, ACK_A, ACK_B, 1'b1},
			{1'b0, 8'h00, 8'h00, 24'h0, 1'b0, 1'b0, 1'b1, STATUS_RUNNING, STAGE_LDO});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_tick(dir_rows[i].tick, 1'b1, dir_rows[i].res);
		tick_ch.valid <= 1'b0;
		drain();

		write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(REG_HEADER_BYTE, CFG_DATA_W'($urandom));
		run_phase(200, STAGE_LDO);

		write_reg(REG_DEVICE_ADDRESS, '1);
		write_reg(REG_HEADER_BYTE, CFG_DATA_W'(8'hFF));
		write_reg(REG_EXPECTED_CHIP_ID, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(TICKS_MAX));
		run_phase(200, STAGE_B6);

		// time out partway through
		write_reg(REG_DEVICE_ADDRESS, '0);
		write_reg(REG_HEADER_BYTE, '0);
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(tick_count + 16'd60));
		run_phase(150, STAGE_B6);

		write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(REG_HEADER_BYTE, CFG_DATA_W'($urandom));
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(16'd1));
		run_phase(200, STAGE_B7);

		write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(REG_EXPECTED_CHIP_ID, CFG_DATA_W'($urandom));
		write_reg(REG_TIMEOUT_TICKS, '0);
		run_phase(400, STAGE_B7);

		// finish the sequence with no timeout pending
		write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(REG_HEADER_BYTE, CFG_DATA_W'($urandom));
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(TICKS_MAX));
		run_phase(60, STAGE_END);

		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(16'd1));
		write_reg(REG_EXPECTED_CHIP_ID, '0);
		write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'({$urandom, $urandom}));
		run_phase(30, STAGE_END);

		repeat (8) @(posedge clk);
		$display("%0d ticks sent, %0d packets sent, mismatch and link-stall cases mixed in",
			ticks_sent, packets_sent);
		$display("final stage %0d, status %0d, halted %0d, %0d mismatches",
			hs_stage, status, halted, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
